// ===== rtl/core/mqec_pkg.sv =====
// ----------------------------------------------------------------------------
// Multi quadrature encoder counter package
// Shared constants and types: encoder pin map, count widths and the control
// bundle that drives one encoder channel.
// ----------------------------------------------------------------------------
package mqec_pkg;

    localparam int NUM_ENCODERS = 9;
    localparam int SLOT_COUNT   = 9;
    localparam int COUNT_BITS   = 16;
    localparam int DELTA_BITS   = 16;
    localparam int SAMPLE_BITS  = 32;
    localparam int PIN_BITS     = $clog2(SAMPLE_BITS);
    localparam int OUT_BITS     = SLOT_COUNT * DELTA_BITS;

    localparam logic A_RESET_LEVEL = 1'b1;

    typedef enum logic
    {
        OP_SAMPLE = 1'b0,
        OP_READ   = 1'b1
    } op_t;

    typedef logic [PIN_BITS-1:0] pin_t;

    localparam pin_t PIN_A [SLOT_COUNT] = '{
        PIN_BITS'(3),  PIN_BITS'(10), PIN_BITS'(13),
        PIN_BITS'(0),  PIN_BITS'(24), PIN_BITS'(27),
        PIN_BITS'(21), PIN_BITS'(18), PIN_BITS'(30)
    };

    localparam pin_t PIN_B [SLOT_COUNT] = '{
        PIN_BITS'(4),  PIN_BITS'(11), PIN_BITS'(14),
        PIN_BITS'(1),  PIN_BITS'(25), PIN_BITS'(28),
        PIN_BITS'(22), PIN_BITS'(19), PIN_BITS'(31)
    };

    typedef logic signed [COUNT_BITS-1:0] count_t;

    typedef struct packed
    {
        logic sample_en;
        logic read_en;
        logic a_bit;
        logic b_bit;
    } chan_ctrl_t;

endpackage

// ===== rtl/core/mqec_channel.sv =====
// ----------------------------------------------------------------------------
// Encoder channel
// Holds the last A level and the saturating pending count of one encoder.
// A rising edge of A steps the count down when B is high and up otherwise.
// ----------------------------------------------------------------------------
module mqec_channel
(
    input  logic                clk,
    input  logic                rst_n,
    input  mqec_pkg::chan_ctrl_t ctrl,
    output mqec_pkg::count_t    count
);
    import mqec_pkg::*;

    localparam count_t COUNT_MAX = {1'b0, {(COUNT_BITS-1){1'b1}}};
    localparam count_t COUNT_MIN = {1'b1, {(COUNT_BITS-1){1'b0}}};
    localparam count_t COUNT_ONE = COUNT_BITS'(1);

    logic   prev_a_reg;
    logic   prev_a_next;
    count_t count_reg;
    count_t count_next;

    always_comb
    begin
        prev_a_next = prev_a_reg;
        count_next  = count_reg;
        if (ctrl.read_en)
        begin
            count_next = '0;
        end
        else if (ctrl.sample_en)
        begin
            prev_a_next = ctrl.a_bit;
            if (ctrl.a_bit && !prev_a_reg)
            begin
                if (ctrl.b_bit)
                begin
                    if (count_reg != COUNT_MIN)
                    begin
                        count_next = count_reg - COUNT_ONE;
                    end
                end
                else
                begin
                    if (count_reg != COUNT_MAX)
                    begin
                        count_next = count_reg + COUNT_ONE;
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_a_reg <= A_RESET_LEVEL;
            count_reg  <= '0;
        end
        else
        begin
            prev_a_reg <= prev_a_next;
            count_reg  <= count_next;
        end
    end

    assign count = count_reg;

endmodule

// ===== rtl/core/multi_quadrature_encoder_counter.sv =====
// ----------------------------------------------------------------------------
// Multi quadrature encoder counter
// Tracks nine x1 quadrature encoders from one 32-bit pin sample and reports
// their pending counts on request.
// ----------------------------------------------------------------------------
// Every input word yields exactly one output word. A word with tuser = 0 is
// a pin sample: each encoder whose A pin rose since the previous sample steps
// its count (down when B is high, up otherwise), and the output word carries
// all zeros. A word with tuser = 1 reads all nine counts, clears them, and
// sets the output tuser flag if any count was nonzero. Counts saturate at the
// signed 16-bit limits. The block takes one word per clock cycle while the
// output side is not stalled; a word passes through an input register and
// then the result register before its result is presented on the output.
module multi_quadrature_encoder_counter
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    input  logic [mqec_pkg::SAMPLE_BITS-1:0] s_axis_tdata,  // sample_word
    input  logic                          s_axis_tuser,  // op
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    output logic [mqec_pkg::OUT_BITS-1:0] m_axis_tdata,  // delta_enc0 .. delta_enc8
    output logic                          m_axis_tuser   // any_changed
);
    import mqec_pkg::*;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    op_t                    in_op_reg;
    logic [SAMPLE_BITS-1:0] in_word_reg;
    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic [OUT_BITS-1:0]    out_data_reg;
    logic [OUT_BITS-1:0]    out_data_next;
    logic                   out_any_reg;
    logic                   out_any_next;

    logic                   advance;
    logic                   fire;
    logic                   in_take;
    logic [OUT_BITS-1:0]    delta_all;
    logic [SLOT_COUNT-1:0]  nonzero;

    assign advance       = !out_valid_reg || m_axis_tready;
    assign fire          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    genvar g;
    generate
        for (g = 0; g < SLOT_COUNT; g++)
        begin : gen_slot
            if (g < NUM_ENCODERS)
            begin : gen_enc
                chan_ctrl_t ctrl;
                count_t     count;

                assign ctrl.sample_en = fire && (in_op_reg == OP_SAMPLE);
                assign ctrl.read_en   = fire && (in_op_reg == OP_READ);
                assign ctrl.a_bit     = in_word_reg[PIN_A[g]];
                assign ctrl.b_bit     = in_word_reg[PIN_B[g]];

                mqec_channel u_channel
                (
                    .clk   (clk),
                    .rst_n (rst_n),
                    .ctrl  (ctrl),
                    .count (count)
                );

                assign nonzero[g] = (count != '0);

                if (COUNT_BITS >= DELTA_BITS)
                begin : gen_trunc
                    assign delta_all[g*DELTA_BITS +: DELTA_BITS] = count[DELTA_BITS-1:0];
                end
                else
                begin : gen_sext
                    assign delta_all[g*DELTA_BITS +: DELTA_BITS] =
                        {{(DELTA_BITS-COUNT_BITS){count[COUNT_BITS-1]}}, count};
                end
            end
            else
            begin : gen_unused
                assign nonzero[g]                            = 1'b0;
                assign delta_all[g*DELTA_BITS +: DELTA_BITS] = '0;
            end
        end
    endgenerate

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_take)
        begin
            in_valid_next = 1'b1;
        end
        else if (fire)
        begin
            in_valid_next = 1'b0;
        end

        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_any_next   = out_any_reg;
        if (fire)
        begin
            out_valid_next = 1'b1;
            if (in_op_reg == OP_READ)
            begin
                out_data_next = delta_all;
                out_any_next  = |nonzero;
            end
            else
            begin
                out_data_next = '0;
                out_any_next  = 1'b0;
            end
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_op_reg   <= op_t'(s_axis_tuser);
            in_word_reg <= s_axis_tdata;
        end
        out_data_reg <= out_data_next;
        out_any_reg  <= out_any_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_any_reg;

endmodule

// ===== verif/testbench.sv =====
// ----------------------------------------------------------------------------
// Multi quadrature encoder counter testbench
// Drives pin samples and read requests into the stream input. Every output
// word is checked against a local model of the nine encoder counters or
// against a fixed expected word where one is given. The stimulus has two parts:
//   - a short directed table;
//   - random traffic with idle gaps on both sides, a long output stall and a
//     drain pause.
// ----------------------------------------------------------------------------
module testbench;

    import mqec_pkg::*;

    localparam int ENC_COUNT     = 9;
    localparam int ENC_BITS      = 16;
    localparam int RANDOM_WORDS  = 1200;
    localparam int RX_HOLD_LEN   = 400;
    localparam int STALL_LIMIT   = 2000;
    localparam int TAIL_CYCLES   = 20;
    localparam int PRINT_LIMIT   = 100;

    typedef logic signed [ENC_BITS-1:0] enc_count_t;

    typedef struct packed
    {
        logic                          any;
        logic [ENC_COUNT*ENC_BITS-1:0] deltas;
    } readout_t;

    typedef struct
    {
        op_t         op;
        logic [31:0] word;
        bit          typed;
        readout_t    want;
    } row_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 s_axis_tvalid;
    logic                 s_axis_tready;
    logic [31:0]          s_axis_tdata;   // sample_word
    logic                 s_axis_tuser;   // op
    logic                 m_axis_tvalid;
    logic                 m_axis_tready;
    logic [OUT_BITS-1:0]  m_axis_tdata;   // delta_enc0 .. delta_enc8
    logic                 m_axis_tuser;   // any_changed

    int          a_pin [ENC_COUNT] = '{3, 10, 13, 0, 24, 27, 21, 18, 30};
    int          b_pin [ENC_COUNT] = '{4, 11, 14, 1, 25, 28, 22, 19, 31};
    logic        last_a [ENC_COUNT];
    enc_count_t  pending [ENC_COUNT];

    readout_t    expected_readouts [$];
    row_t        directed_rows [$];
    int          mismatches = 0;
    int          stall_cycles = 0;
    int          rx_hold = 0;
    bit          quiet = 1'b0;

    multi_quadrature_encoder_counter dut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic readout_t step_encoders(input op_t op, input logic [31:0] word);
        readout_t r;
        logic     a;
        logic     b;
        r = '0;
        if (op == OP_SAMPLE)
        begin
            for (int i = 0; i < ENC_COUNT; i++)
            begin
                a = word[a_pin[i]];
                b = word[b_pin[i]];
                if (a && !last_a[i])
                begin
                    if (b && pending[i] != enc_count_t'(16'h8000))
                        pending[i] = pending[i] - enc_count_t'(1);
                    else if (!b && pending[i] != enc_count_t'(16'h7fff))
                        pending[i] = pending[i] + enc_count_t'(1);
                end
                last_a[i] = a;
            end
        end
        else
        begin
            for (int i = 0; i < ENC_COUNT; i++)
            begin
                if (pending[i] != 0)
                    r.any = 1'b1;
                r.deltas[ENC_BITS*i +: ENC_BITS] = pending[i];
                pending[i] = '0;
            end
        end
        return r;
    endfunction

    task automatic report_mismatch(input string msg);
        if (mismatches < PRINT_LIMIT)
            $display("mismatch at %0t: %s", $time, msg);
        mismatches++;
    endtask

    task automatic send_word(input op_t op, input logic [31:0] word, input bit typed,
                             input readout_t want);
        readout_t predicted;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= op;
        s_axis_tdata  <= word;
        do
            @(posedge clk);
        while (!s_axis_tready);
        predicted = step_encoders(op, word);
        expected_readouts.push_back(typed ? want : predicted);
        if (!quiet && $urandom_range(99) < 9)
        begin
            s_axis_tvalid <= 1'b0;
            s_axis_tdata  <= $urandom;
            repeat ($urandom_range(1, 4))
                @(posedge clk);
        end
    endtask

    task automatic wait_for_readouts();
        s_axis_tvalid <= 1'b0;
        wait (expected_readouts.size() == 0);
        @(posedge clk);
    endtask

    initial
    begin
        rst_n <= 1'b0;
        repeat (9)
            @(posedge clk);
        rst_n <= 1'b1;
    end

    initial
    begin
        m_axis_tready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rx_hold > 0)
            begin
                rx_hold--;
                m_axis_tready <= 1'b0;
            end
            else
                m_axis_tready <= quiet || ($urandom_range(99) >= 9);
        end
    end

    always @(posedge clk)
    begin
        readout_t want;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            if (expected_readouts.size() == 0)
                report_mismatch($sformatf("unexpected word, tuser=%0b", m_axis_tuser));
            else
            begin
                want = expected_readouts.pop_front();
                if (m_axis_tuser !== want.any)
                    report_mismatch($sformatf("any_changed %0b, want %0b",
                                              m_axis_tuser, want.any));
                for (int i = 0; i < ENC_COUNT; i++)
                    if (m_axis_tdata[ENC_BITS*i +: ENC_BITS] !== want.deltas[ENC_BITS*i +: ENC_BITS])
                        report_mismatch($sformatf("delta_enc%0d %0d, want %0d", i,
                            $signed(m_axis_tdata[ENC_BITS*i +: ENC_BITS]),
                            $signed(want.deltas[ENC_BITS*i +: ENC_BITS])));
            end
        end
    end

    always @(posedge clk)
    begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            stall_cycles <= 0;
        else if (stall_cycles >= STALL_LIMIT)
        begin
            $display("*** FAILED ***");
            $finish;
        end
        else
            stall_cycles <= stall_cycles + 1;
    end

    initial
    begin
        logic [31:0] a_mask;
        logic [31:0] b_mask;
        logic [31:0] word;
        op_t         op;
        row_t        row;

        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= OP_SAMPLE;

        a_mask = '0;
        b_mask = '0;
        for (int i = 0; i < ENC_COUNT; i++)
        begin
            last_a[i]  = 1'b1;
            pending[i] = '0;
            a_mask[a_pin[i]] = 1'b1;
            b_mask[b_pin[i]] = 1'b1;
        end

        // After reset the counts are zero, and an A pin that is already high
        // in the first sample does not count as an edge.
        directed_rows.push_back('{OP_READ,   32'h0000_0000, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'hffff_ffff, 1'b1, '0});
        directed_rows.push_back('{OP_READ,   32'hffff_ffff, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'h0000_0000, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, a_mask,        1'b1, '0});
        directed_rows.push_back('{OP_READ,   32'h0000_0000, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   32'h0000_0000, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'h0000_0000, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'hffff_ffff, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'hffff_ffff, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, b_mask,        1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, a_mask | b_mask, 1'b1, '0});
        directed_rows.push_back('{OP_READ,   32'h0000_0000, 1'b0, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'h0000_0000, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, 32'h4000_0000, 1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, ~a_mask,       1'b1, '0});
        directed_rows.push_back('{OP_SAMPLE, a_mask | 32'h1200_0012, 1'b1, '0});
        directed_rows.push_back('{OP_READ,   32'h0000_0000, 1'b0, '0});
        directed_rows.push_back('{OP_READ,   32'h5555_aaaa, 1'b1, '0});

        do
            @(posedge clk);
        while (!rst_n);

        foreach (directed_rows[k])
        begin
            row = directed_rows[k];
            send_word(row.op, row.word, row.typed, row.want);
        end
        wait_for_readouts();

        for (int n = 0; n < RANDOM_WORDS; n++)
        begin
            quiet = (n >= 200 && n < 500);
            if (n == 600)
                rx_hold = RX_HOLD_LEN;
            if (n == 900)
                wait_for_readouts();
            op = ($urandom_range(9) == 0) ? OP_READ : OP_SAMPLE;
            case ($urandom_range(9))
                0:       word = '0;
                1:       word = '1;
                2:       word = a_mask | ($urandom & b_mask);
                default: word = $urandom;
            endcase
            send_word(op, word, 1'b0, '0);
        end
        quiet = 1'b0;
        send_word(OP_READ, $urandom, 1'b0, '0);
        send_word(OP_READ, $urandom, 1'b1, '0);

        wait_for_readouts();
        repeat (TAIL_CYCLES)
            @(posedge clk);
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
